FILE: rtl/egd_pkg.sv
package egd_pkg;

    // Field widths
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned VOL_W      = 7;
    localparam int unsigned ACC_W      = 4;
    localparam int unsigned DETENT_W   = 3;
    localparam int unsigned RAPID_W    = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 24;

    // Volume range and reset level
    localparam logic [VOL_W-1:0] VOL_MAX   = 7'd100;
    localparam logic [VOL_W-1:0] VOL_RESET = 7'd50;

    // Configuration reset values
    localparam logic [CFG_W-1:0]    DBL_CLICK_RST    = 16'd300;
    localparam logic [CFG_W-1:0]    LONG_PRESS_RST   = 16'd2000;
    localparam logic [CFG_W-1:0]    RAPID_CLICK_RST  = 16'd500;
    localparam logic [RAPID_W-1:0]  RAPID_TARGET_RST = 4'd5;
    localparam logic [DETENT_W-1:0] DETENT_RST       = 3'd2;
    localparam logic [CFG_W-1:0]    BLINK_HALF_RST   = 16'd500;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DBL_CLICK    = 3'd0,
        CFG_LONG_PRESS   = 3'd1,
        CFG_RAPID_CLICK  = 3'd2,
        CFG_RAPID_TARGET = 3'd3,
        CFG_DETENT       = 3'd4,
        CFG_BLINK_HALF   = 3'd5
    } cfg_idx_t;

    // Seek event codes
    typedef enum logic [1:0] {
        SEEK_NONE = 2'd0,
        SEEK_FWD  = 2'd1,
        SEEK_REW  = 2'd2
    } seek_t;

    // Menu step codes (two's complement)
    localparam logic [1:0] STEP_NONE = 2'b00;
    localparam logic [1:0] STEP_UP   = 2'b01;
    localparam logic [1:0] STEP_DOWN = 2'b11;

    typedef struct packed {
        logic [CFG_W-1:0]    dbl_click_ms;
        logic [CFG_W-1:0]    long_press_ms;
        logic [CFG_W-1:0]    rapid_click_ms;
        logic [RAPID_W-1:0]  rapid_click_target;
        logic [DETENT_W-1:0] detent_counts;
        logic [CFG_W-1:0]    blink_half_period_ms;
    } cfg_t;

    // Button status shared with the encoder and LED logic
    typedef struct packed {
        logic pressed;
        logic press_edge;
    } btn_stat_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              clk_level;
        logic              dt_level;
        logic              button_level;
        logic              in_menu;
        logic              at_top_menu;
    } sample_t;

    typedef struct packed {
        logic              led_on;
        logic              display_toggle;
        logic              single_click;
        logic              dbl_click;
        logic              exit_to_main;
        logic              play_toggle;
        logic              volume_changed;
        logic [VOL_W-1:0]  volume_level;
        seek_t             seek_event;
        logic [1:0]        menu_step;
    } result_t;

    // Magnitude of a detent accumulator (range -7..7)
    function automatic logic [DETENT_W-1:0] acc_mag(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] neg;
        neg = -v;
        return v[ACC_W-1] ? neg[DETENT_W-1:0] : v[DETENT_W-1:0];
    endfunction

endpackage

FILE: rtl/egd_rotary.sv
module egd_rotary (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step_en,
    input  logic                           clk_level,
    input  logic                           dt_level,
    input  logic                           in_menu,
    input  egd_pkg::btn_stat_t             btn,
    input  logic [egd_pkg::DETENT_W-1:0]   detent_counts,
    output logic [1:0]                     menu_step,
    output egd_pkg::seek_t                 seek_event,
    output logic [egd_pkg::VOL_W-1:0]      volume_level,
    output logic                           volume_changed,
    output logic                           seek_mode_turn
);
    import egd_pkg::*;

    logic                    prev_clk_reg,   prev_clk_next;
    logic                    seek_mode_reg,  seek_mode_next;
    logic signed [ACC_W-1:0] menu_accum_reg, menu_accum_next;
    logic signed [ACC_W-1:0] seek_accum_reg, seek_accum_next;
    logic [VOL_W-1:0]        volume_reg,     volume_next;

    logic                    turn;
    logic                    dir_up;
    logic signed [ACC_W-1:0] delta;
    logic signed [ACC_W-1:0] menu_sum;
    logic signed [ACC_W-1:0] seek_sum;
    logic                    menu_hit;
    logic                    seek_hit;

    // Edge detect and detent accumulation
    assign turn     = clk_level != prev_clk_reg;
    assign dir_up   = dt_level != clk_level;
    assign delta    = dir_up ? 4'sd1 : -4'sd1;
    assign menu_sum = menu_accum_reg + delta;
    assign seek_sum = seek_accum_reg + delta;
    assign menu_hit = acc_mag(menu_sum) >= detent_counts;
    assign seek_hit = acc_mag(seek_sum) >= detent_counts;

    // Turn handling: menu step, seek or volume
    always_comb
    begin
        menu_accum_next = menu_accum_reg;
        seek_accum_next = seek_accum_reg;
        volume_next     = volume_reg;
        seek_mode_turn  = seek_mode_reg;
        menu_step       = STEP_NONE;
        seek_event      = SEEK_NONE;
        volume_changed  = 1'b0;
        if (turn)
        begin
            if (in_menu)
            begin
                menu_accum_next = menu_sum;
                if (menu_hit)
                begin
                    menu_step       = (menu_sum > 4'sd0) ? STEP_UP : STEP_DOWN;
                    menu_accum_next = '0;
                end
            end
            else if (btn.pressed)
            begin
                seek_mode_turn  = 1'b1;
                seek_accum_next = seek_sum;
                if (seek_hit)
                begin
                    seek_event      = (seek_sum > 4'sd0) ? SEEK_FWD : SEEK_REW;
                    seek_accum_next = '0;
                end
            end
            else
            begin
                seek_accum_next = '0;
                seek_mode_turn  = 1'b0;
                if (dir_up)
                begin
                    if (volume_reg < VOL_MAX)
                        volume_next = volume_reg + 7'd1;
                end
                else if (volume_reg != '0)
                begin
                    volume_next = volume_reg - 7'd1;
                end
                volume_changed = 1'b1;
            end
        end
    end

    // A new press ends seek mode, even after a turn in the same sample
    assign seek_mode_next = btn.press_edge ? 1'b0 : seek_mode_turn;
    assign prev_clk_next  = clk_level;
    assign volume_level   = volume_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_clk_reg   <= 1'b1;
            seek_mode_reg  <= 1'b0;
            menu_accum_reg <= '0;
            seek_accum_reg <= '0;
            volume_reg     <= VOL_RESET;
        end
        else if (step_en)
        begin
            prev_clk_reg   <= prev_clk_next;
            seek_mode_reg  <= seek_mode_next;
            menu_accum_reg <= menu_accum_next;
            seek_accum_reg <= seek_accum_next;
            volume_reg     <= volume_next;
        end
    end

    a_volume_range: assert property (@(posedge clk) disable iff (!rst_n)
        volume_reg <= VOL_MAX)
        else $error("volume out of range");

    a_menu_accum_range: assert property (@(posedge clk) disable iff (!rst_n)
        menu_accum_reg != {1'b1, {(ACC_W-1){1'b0}}})
        else $error("menu accumulator overflow");

    a_seek_accum_range: assert property (@(posedge clk) disable iff (!rst_n)
        seek_accum_reg != {1'b1, {(ACC_W-1){1'b0}}})
        else $error("seek accumulator overflow");

endmodule

FILE: rtl/egd_button.sv
module egd_button (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  logic [egd_pkg::TIME_W-1:0]    now_ms,
    input  logic                          button_level,
    input  logic                          in_menu,
    input  logic                          at_top_menu,
    input  logic                          seek_mode_turn,
    input  egd_pkg::cfg_t                 cfg,
    output egd_pkg::btn_stat_t            btn,
    output logic                          play_toggle,
    output logic                          exit_to_main,
    output logic                          dbl_click,
    output logic                          single_click,
    output logic                          display_toggle
);
    import egd_pkg::*;

    logic               prev_button_reg,   prev_button_next;
    logic [TIME_W-1:0]  press_start_reg,   press_start_next;
    logic               long_done_reg,     long_done_next;
    logic               click_pending_reg, click_pending_next;
    logic [TIME_W-1:0]  click_time_reg,    click_time_next;
    logic [RAPID_W-1:0] rapid_count_reg,   rapid_count_next;
    logic [TIME_W-1:0]  last_rapid_reg,    last_rapid_next;

    logic [TIME_W-1:0]  held;
    logic [TIME_W-1:0]  since_click;
    logic [TIME_W-1:0]  since_rapid;
    logic [TIME_W-1:0]  dbl_win;
    logic [TIME_W-1:0]  long_win;
    logic [TIME_W-1:0]  rapid_win;
    logic [RAPID_W-1:0] rapid_base;
    logic [RAPID_W-1:0] rapid_inc;
    logic               click_new;

    assign btn.pressed    = !button_level;
    assign btn.press_edge = !button_level && prev_button_reg;

    // Elapsed times, modulo 2^32
    assign held        = now_ms - press_start_reg;
    assign since_click = now_ms - click_time_reg;
    assign since_rapid = now_ms - last_rapid_reg;
    assign dbl_win     = {{(TIME_W-CFG_W){1'b0}}, cfg.dbl_click_ms};
    assign long_win    = {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms};
    assign rapid_win   = {{(TIME_W-CFG_W){1'b0}}, cfg.rapid_click_ms};

    // Rapid run counter restarts after a long gap
    assign rapid_base = (since_rapid > rapid_win) ? '0 : rapid_count_reg;
    assign rapid_inc  = rapid_base + 4'd1;

    // Press, release and click window
    always_comb
    begin
        press_start_next   = press_start_reg;
        long_done_next     = long_done_reg;
        click_pending_next = click_pending_reg;
        click_time_next    = click_time_reg;
        rapid_count_next   = rapid_count_reg;
        last_rapid_next    = last_rapid_reg;
        click_new          = 1'b0;
        play_toggle        = 1'b0;
        exit_to_main       = 1'b0;
        dbl_click          = 1'b0;
        single_click       = 1'b0;
        display_toggle     = 1'b0;

        if (btn.pressed)
        begin
            if (btn.press_edge)
            begin
                press_start_next = now_ms;
                long_done_next   = 1'b0;
            end
            else if (!long_done_reg && !seek_mode_turn && (held > long_win))
            begin
                if (in_menu && !at_top_menu)
                    exit_to_main = 1'b1;
                else
                    play_toggle = 1'b1;
                long_done_next = 1'b1;
            end
        end
        else if (!prev_button_reg)
        begin
            // release of a short press
            if (!long_done_reg && (held <= dbl_win))
            begin
                if (click_pending_reg && (since_click < dbl_win))
                begin
                    click_pending_next = 1'b0;
                    dbl_click          = 1'b1;
                end
                else
                begin
                    click_pending_next = 1'b1;
                    click_time_next    = now_ms;
                    click_new          = 1'b1;
                end
                last_rapid_next = now_ms;
                if (rapid_inc >= cfg.rapid_click_target)
                begin
                    display_toggle   = 1'b1;
                    rapid_count_next = '0;
                end
                else
                begin
                    rapid_count_next = rapid_inc;
                end
            end
        end

        // Pending click expires; a click taken this sample has zero age
        if (click_pending_next && !click_new && (since_click > dbl_win))
        begin
            click_pending_next = 1'b0;
            single_click       = in_menu;
        end
    end

    assign prev_button_next = button_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_button_reg   <= 1'b1;
            press_start_reg   <= '0;
            long_done_reg     <= 1'b0;
            click_pending_reg <= 1'b0;
            click_time_reg    <= '0;
            rapid_count_reg   <= '0;
            last_rapid_reg    <= '0;
        end
        else if (step_en)
        begin
            prev_button_reg   <= prev_button_next;
            press_start_reg   <= press_start_next;
            long_done_reg     <= long_done_next;
            click_pending_reg <= click_pending_next;
            click_time_reg    <= click_time_next;
            rapid_count_reg   <= rapid_count_next;
            last_rapid_reg    <= last_rapid_next;
        end
    end

    a_long_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(play_toggle && exit_to_main))
        else $error("play toggle and menu exit together");

    a_long_once: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && (play_toggle || exit_to_main)) |=> long_done_reg)
        else $error("long press not latched");

    a_click_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        !(dbl_click && single_click))
        else $error("single and double click together");

endmodule

FILE: rtl/egd_led.sv
module egd_led (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step_en,
    input  logic [egd_pkg::TIME_W-1:0]   now_ms,
    input  egd_pkg::btn_stat_t           btn,
    input  logic [egd_pkg::CFG_W-1:0]    blink_half_period_ms,
    output logic                         led_on
);
    import egd_pkg::*;

    logic              flashing_reg,  flashing_next;
    logic              led_state_reg, led_state_next;
    logic [TIME_W-1:0] toggle_reg,    toggle_next;
    logic [TIME_W-1:0] since_toggle;

    assign since_toggle = now_ms - toggle_reg;

    // Blink while held, steady on when released
    always_comb
    begin
        flashing_next  = flashing_reg;
        led_state_next = led_state_reg;
        toggle_next    = toggle_reg;
        if (btn.pressed)
        begin
            if (!flashing_reg)
            begin
                flashing_next  = 1'b1;
                led_state_next = 1'b0;
                toggle_next    = now_ms;
            end
            else if (since_toggle >= {{(TIME_W-CFG_W){1'b0}}, blink_half_period_ms})
            begin
                led_state_next = !led_state_reg;
                toggle_next    = now_ms;
            end
        end
        else if (flashing_reg)
        begin
            flashing_next  = 1'b0;
            led_state_next = 1'b1;
        end
    end

    assign led_on = led_state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flashing_reg  <= 1'b0;
            led_state_reg <= 1'b1;
            toggle_reg    <= '0;
        end
        else if (step_en)
        begin
            flashing_reg  <= flashing_next;
            led_state_reg <= led_state_next;
            toggle_reg    <= toggle_next;
        end
    end

    a_led_idle_on: assert property (@(posedge clk) disable iff (!rst_n)
        !flashing_reg |-> led_state_reg)
        else $error("LED off while not flashing");

    a_led_start: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && btn.pressed && !flashing_reg) |=> (flashing_reg && !led_state_reg))
        else $error("blink did not start");

    a_led_release: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && !btn.pressed) |=> (!flashing_reg && led_state_reg))
        else $error("LED not restored on release");

endmodule

FILE: rtl/encoder_button_gesture_decoder.sv
// Rotary encoder and push button gesture decoder. Each transaction on the
// input stream is one pin sample with its millisecond timestamp; each sample
// yields exactly one result transaction carrying the menu step, seek event,
// volume, button gestures and LED level. The sample is registered on accept
// and its full state update (encoder detents, volume, press timing, click
// windows, rapid click run, LED blink) is resolved into the result register
// once that slot is free, so a result is presented from the result register,
// and one sample is taken every clock while the output side keeps up.
// A stalled output holds one result and one sample in the input register
// before tready drops. Configuration writes take effect at once and are meant
// to be made while no transaction is in flight.
module encoder_button_gesture_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [egd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [egd_pkg::CFG_W-1:0]          cfg_data,
    // sample stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // now_ms[31:0], clk_level, dt_level, button_level, in_menu, at_top_menu, zero pad
    input  logic [egd_pkg::IN_DATA_W-1:0]      s_tdata,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // menu_step[1:0], seek_event[1:0], volume_level[6:0], volume_changed,
    // play_toggle, exit_to_main, dbl_click, single_click, display_toggle,
    // led_on, zero pad
    output logic [egd_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import egd_pkg::*;

    cfg_t      cfg_reg;
    logic      in_valid_reg,  in_valid_next;
    sample_t   sample_reg;
    logic      out_valid_reg, out_valid_next;
    result_t   result_reg;
    result_t   result_next;

    logic      in_load;
    logic      advance;
    btn_stat_t btn;
    logic      seek_mode_turn;
    logic [1:0] menu_step;
    seek_t     seek_event;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dbl_click_ms         <= DBL_CLICK_RST;
            cfg_reg.long_press_ms        <= LONG_PRESS_RST;
            cfg_reg.rapid_click_ms       <= RAPID_CLICK_RST;
            cfg_reg.rapid_click_target   <= RAPID_TARGET_RST;
            cfg_reg.detent_counts        <= DETENT_RST;
            cfg_reg.blink_half_period_ms <= BLINK_HALF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DBL_CLICK:    cfg_reg.dbl_click_ms         <= cfg_data;
                CFG_LONG_PRESS:   cfg_reg.long_press_ms        <= cfg_data;
                CFG_RAPID_CLICK:  cfg_reg.rapid_click_ms       <= cfg_data;
                CFG_RAPID_TARGET: cfg_reg.rapid_click_target   <= cfg_data[RAPID_W-1:0];
                CFG_DETENT:       cfg_reg.detent_counts        <= cfg_data[DETENT_W-1:0];
                CFG_BLINK_HALF:   cfg_reg.blink_half_period_ms <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: sample moves to the result register when that slot frees up
    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign in_load        = s_tvalid && s_tready;
    assign in_valid_next  = in_load ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            sample_reg.now_ms       <= s_tdata[TIME_W-1:0];
            sample_reg.clk_level    <= s_tdata[TIME_W];
            sample_reg.dt_level     <= s_tdata[TIME_W+1];
            sample_reg.button_level <= s_tdata[TIME_W+2];
            sample_reg.in_menu      <= s_tdata[TIME_W+3];
            sample_reg.at_top_menu  <= s_tdata[TIME_W+4];
        end
    end

    egd_rotary u_rotary (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (advance),
        .clk_level      (sample_reg.clk_level),
        .dt_level       (sample_reg.dt_level),
        .in_menu        (sample_reg.in_menu),
        .btn            (btn),
        .detent_counts  (cfg_reg.detent_counts),
        .menu_step      (menu_step),
        .seek_event     (seek_event),
        .volume_level   (result_next.volume_level),
        .volume_changed (result_next.volume_changed),
        .seek_mode_turn (seek_mode_turn)
    );

    egd_button u_button (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (advance),
        .now_ms         (sample_reg.now_ms),
        .button_level   (sample_reg.button_level),
        .in_menu        (sample_reg.in_menu),
        .at_top_menu    (sample_reg.at_top_menu),
        .seek_mode_turn (seek_mode_turn),
        .cfg            (cfg_reg),
        .btn            (btn),
        .play_toggle    (result_next.play_toggle),
        .exit_to_main   (result_next.exit_to_main),
        .dbl_click      (result_next.dbl_click),
        .single_click   (result_next.single_click),
        .display_toggle (result_next.display_toggle)
    );

    egd_led u_led (
        .clk                  (clk),
        .rst_n                (rst_n),
        .step_en              (advance),
        .now_ms               (sample_reg.now_ms),
        .btn                  (btn),
        .blink_half_period_ms (cfg_reg.blink_half_period_ms),
        .led_on               (result_next.led_on)
    );

    assign result_next.menu_step  = menu_step;
    assign result_next.seek_event = seek_event;

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-$bits(result_t)){1'b0}}, result_reg};

    a_sample_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending sample dropped");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with room available");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced sample produced no result");

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import egd_pkg::*;

    // Spare register index, no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd6;

    // Expected gesture results, predicted from accepted pin samples
    class gesture_scoreboard;
        logic [CFG_W-1:0]    dbl_win_ms;
        logic [CFG_W-1:0]    long_ms;
        logic [CFG_W-1:0]    rapid_gap_ms;
        logic [RAPID_W-1:0]  rapid_target;
        logic [DETENT_W-1:0] detent;
        logic [CFG_W-1:0]    blink_ms;

        bit                  prev_clk;
        bit                  prev_btn;
        bit                  long_done;
        bit                  seek_mode;
        bit                  click_pending;
        bit                  led_flashing;
        bit                  led_state;
        logic [TIME_W-1:0]   press_t;
        logic [TIME_W-1:0]   click_t;
        logic [TIME_W-1:0]   rapid_t;
        logic [TIME_W-1:0]   led_t;
        int                  menu_acc;
        int                  seek_acc;
        logic [VOL_W-1:0]    volume;
        logic [RAPID_W-1:0]  rapid_cnt;

        result_t             expected_q[$];
        int                  errors;

        function new();
            dbl_win_ms    = DBL_CLICK_RST;
            long_ms       = LONG_PRESS_RST;
            rapid_gap_ms  = RAPID_CLICK_RST;
            rapid_target  = RAPID_TARGET_RST;
            detent        = DETENT_RST;
            blink_ms      = BLINK_HALF_RST;
            prev_clk      = 1'b1;
            prev_btn      = 1'b1;
            long_done     = 1'b0;
            seek_mode     = 1'b0;
            click_pending = 1'b0;
            led_flashing  = 1'b0;
            led_state     = 1'b1;
            press_t       = '0;
            click_t       = '0;
            rapid_t       = '0;
            led_t         = '0;
            menu_acc      = 0;
            seek_acc      = 0;
            volume        = VOL_RESET;
            rapid_cnt     = '0;
            errors        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_DBL_CLICK:    dbl_win_ms   = val;
                CFG_LONG_PRESS:   long_ms      = val;
                CFG_RAPID_CLICK:  rapid_gap_ms = val;
                CFG_RAPID_TARGET: rapid_target = val[RAPID_W-1:0];
                CFG_DETENT:       detent       = val[DETENT_W-1:0];
                CFG_BLINK_HALF:   blink_ms     = val;
                default: ;
            endcase
        endfunction

        // Advance the decoder state by one accepted sample
        function void note_sample(logic [IN_DATA_W-1:0] d);
            logic [TIME_W-1:0] now;
            logic [TIME_W-1:0] held;
            logic [TIME_W-1:0] since;
            bit                enc_clk;
            bit                enc_dt;
            bit                btn;
            bit                menu;
            bit                at_main;
            bit                pressed;
            bit                released;
            bit                fwd;
            int                acc_abs;
            result_t           r;

            now      = d[31:0];
            enc_clk  = d[32];
            enc_dt   = d[33];
            btn      = d[34];
            menu     = d[35];
            at_main  = d[36];
            pressed  = !btn;
            released = !prev_btn && btn;
            held     = pressed ? now - press_t : '0;
            fwd      = enc_dt != enc_clk;
            r        = '0;

            // encoder edge: menu step, seek or volume
            if (enc_clk != prev_clk) begin
                if (menu) begin
                    menu_acc += fwd ? 1 : -1;
                    acc_abs = (menu_acc < 0) ? -menu_acc : menu_acc;
                    if (acc_abs >= int'(detent)) begin
                        r.menu_step = (menu_acc > 0) ? STEP_UP : STEP_DOWN;
                        menu_acc = 0;
                    end
                end else if (pressed) begin
                    seek_mode = 1'b1;
                    seek_acc += fwd ? 1 : -1;
                    acc_abs = (seek_acc < 0) ? -seek_acc : seek_acc;
                    if (acc_abs >= int'(detent)) begin
                        r.seek_event = (seek_acc > 0) ? SEEK_FWD : SEEK_REW;
                        seek_acc = 0;
                    end
                end else begin
                    seek_acc  = 0;
                    seek_mode = 1'b0;
                    if (fwd) begin
                        if (volume < VOL_MAX)
                            volume = volume + 1'b1;
                    end else if (volume != '0) begin
                        volume = volume - 1'b1;
                    end
                    r.volume_changed = 1'b1;
                end
            end

            // press timing, long press, clicks
            if (pressed) begin
                if (prev_btn) begin
                    press_t   = now;
                    long_done = 1'b0;
                    seek_mode = 1'b0;
                end else if (!long_done && !seek_mode && held > TIME_W'(long_ms)) begin
                    if (menu && !at_main)
                        r.exit_to_main = 1'b1;
                    else
                        r.play_toggle = 1'b1;
                    long_done = 1'b1;
                end
            end else if (released) begin
                since = now - press_t;
                if (!long_done && since <= TIME_W'(dbl_win_ms)) begin
                    since = now - click_t;
                    if (click_pending && since < TIME_W'(dbl_win_ms)) begin
                        click_pending = 1'b0;
                        r.dbl_click   = 1'b1;
                    end else begin
                        click_pending = 1'b1;
                        click_t       = now;
                    end
                    since = now - rapid_t;
                    if (since > TIME_W'(rapid_gap_ms))
                        rapid_cnt = '0;
                    rapid_cnt = rapid_cnt + 1'b1;
                    rapid_t   = now;
                    if (rapid_cnt >= rapid_target) begin
                        r.display_toggle = 1'b1;
                        rapid_cnt = '0;
                    end
                end
            end

            // pending click expires
            since = now - click_t;
            if (click_pending && since > TIME_W'(dbl_win_ms)) begin
                click_pending = 1'b0;
                if (menu)
                    r.single_click = 1'b1;
            end

            // LED blinks while held
            if (pressed) begin
                since = now - led_t;
                if (!led_flashing) begin
                    led_flashing = 1'b1;
                    led_state    = 1'b0;
                    led_t        = now;
                end else if (since >= TIME_W'(blink_ms)) begin
                    led_state = !led_state;
                    led_t     = now;
                end
            end else if (led_flashing) begin
                led_flashing = 1'b0;
                led_state    = 1'b1;
            end

            prev_clk       = enc_clk;
            prev_btn       = btn;
            r.volume_level = volume;
            r.led_on       = led_state;
            expected_q.push_back(r);
        endfunction

        function void field_check(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Compare one result transaction with the oldest expectation
        function void check_result(logic [OUT_DATA_W-1:0] d);
            result_t e;
            if (expected_q.size() == 0) begin
                $error("result transaction %h with no sample outstanding", d);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            field_check("menu_step",      e.menu_step,      d[1:0]);
            field_check("seek_event",     e.seek_event,     d[3:2]);
            field_check("volume_level",   e.volume_level,   d[10:4]);
            field_check("volume_changed", e.volume_changed, d[11]);
            field_check("play_toggle",    e.play_toggle,    d[12]);
            field_check("exit_to_main",   e.exit_to_main,   d[13]);
            field_check("dbl_click",      e.dbl_click,      d[14]);
            field_check("single_click",   e.single_click,   d[15]);
            field_check("display_toggle", e.display_toggle, d[16]);
            field_check("led_on",         e.led_on,         d[17]);
            field_check("pad",            0,                d[23:18]);
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    gesture_scoreboard sb = new();

    // pin levels and time of the next sample
    logic [TIME_W-1:0] t_ms      = '0;
    bit                pin_clk   = 1'b1;
    bit                pin_dt    = 1'b1;
    bit                pin_btn   = 1'b1;
    bit                menu_open = 1'b0;
    bit                top_menu  = 1'b0;
    bit                tx_burst  = 1'b0;
    bit                rx_steady = 1'b0;
    int                stall_left = 0;
    int                phase_samples = 0;

    encoder_button_gesture_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // result side back-pressure: mostly ready, short stalls, a few long ones
    always @(posedge clk)
    begin
        if (rx_steady) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 70) begin
            m_tready <= 1'b1;
        end else begin
            m_tready   <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // value just below, at or just above a threshold
    function automatic logic [TIME_W-1:0] near(int unsigned thr);
        if (thr == 0)
            return $urandom_range(0, 1);
        return thr - 1 + $urandom_range(0, 2);
    endfunction

    // one sample transaction from the current pin levels
    task automatic send_sample();
        int gap;
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {3'b000, top_menu, menu_open, pin_btn, pin_dt, pin_clk, t_ms};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        sb.note_sample(s_tdata);
        phase_samples++;
    endtask

    // stop sending until every result is back, then let the pipe settle
    task automatic drain();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (sb.outstanding() > 0 && guard < 5000) begin
            @(posedge clk);
            guard++;
        end
        if (sb.outstanding() > 0) begin
            $error("%0d results never arrived", sb.outstanding());
            sb.errors++;
            sb.expected_q.delete();
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic write_all(logic [CFG_W-1:0] dbl, logic [CFG_W-1:0] lng,
                             logic [CFG_W-1:0] rap, logic [CFG_W-1:0] tgt,
                             logic [CFG_W-1:0] det, logic [CFG_W-1:0] blk);
        cfg_write(CFG_DBL_CLICK, dbl);
        cfg_write(CFG_LONG_PRESS, lng);
        cfg_write(CFG_RAPID_CLICK, rap);
        cfg_write(CFG_RAPID_TARGET, tgt);
        cfg_write(CFG_DETENT, det);
        cfg_write(CFG_BLINK_HALF, blk);
        cfg_we <= 1'b0;
    endtask

    task automatic release_if_held();
        if (!pin_btn) begin
            pin_btn = 1'b1;
            t_ms += $urandom_range(0, 30);
            send_sample();
        end
    endtask

    // run of encoder edges: volume, menu steps or seek while held
    task automatic turn_run();
        int  n;
        int  i;
        bit  fwd;
        bit  fixed_dir;
        bit  hold;
        if ($urandom_range(0, 7) == 0) begin
            n         = $urandom_range(40, 70);
            menu_open = 1'b0;
            hold      = 1'b0;
            release_if_held();
        end else begin
            n    = $urandom_range(1, 2 * int'(sb.detent) + 2);
            hold = !menu_open && $urandom_range(0, 2) == 0;
        end
        fixed_dir = $urandom_range(0, 4) != 0;
        fwd       = 1'($urandom_range(0, 1));
        if (hold) begin
            release_if_held();
            pin_btn = 1'b0;
            // the press either stands alone or rides on the first edge
            if ($urandom_range(0, 1)) begin
                t_ms += $urandom_range(1, 20);
                send_sample();
            end
        end
        for (i = 0; i < n; i++) begin
            if (!fixed_dir)
                fwd = 1'($urandom_range(0, 1));
            pin_clk = !pin_clk;
            pin_dt  = fwd ? !pin_clk : pin_clk;
            t_ms += $urandom_range(0, 15);
            send_sample();
        end
        if (hold) begin
            pin_btn = 1'b1;
            t_ms += $urandom_range(0, 40);
            send_sample();
        end
    endtask

    // short clicks with gaps around the double click and rapid windows
    task automatic click_run();
        int                n;
        int                i;
        int                r;
        int unsigned       hold_ms;
        int unsigned       gap_ms;
        int unsigned       target;
        release_if_held();
        n = $urandom_range(1, int'(sb.rapid_target) + 2);
        gap_ms = $urandom_range(1, 60);
        for (i = 0; i < n; i++) begin
            hold_ms = ($urandom_range(0, 3) == 0) ? near(sb.dbl_win_ms)
                                                  : $urandom_range(0, sb.dbl_win_ms / 2);
            pin_btn = 1'b0;
            t_ms += gap_ms;
            send_sample();
            pin_btn = 1'b1;
            t_ms += hold_ms;
            send_sample();
            // next release-to-release spacing
            r = $urandom_range(0, 2);
            if (r == 0)
                target = near(sb.dbl_win_ms);
            else if (r == 1)
                target = near(sb.rapid_gap_ms);
            else
                target = $urandom_range(0, sb.rapid_gap_ms + sb.dbl_win_ms / 4 + 1);
            gap_ms = (target > hold_ms) ? target - hold_ms : 0;
        end
    endtask

    // held button: LED blink, long press, sometimes spoiled by a turn
    task automatic long_press();
        int                k;
        int                i;
        logic [TIME_W-1:0] pt;
        release_if_held();
        pin_btn = 1'b0;
        t_ms += $urandom_range(1, 100);
        send_sample();
        pt = t_ms;
        k = $urandom_range(2, 8);
        for (i = 0; i < k; i++) begin
            if (i == 0 && $urandom_range(0, 4) < 2)
                t_ms = pt + near(sb.long_ms);
            else if ($urandom_range(0, 1))
                t_ms += near(sb.blink_ms);
            else
                t_ms += $urandom_range(1, sb.long_ms / 2 + 1);
            if ($urandom_range(0, 4) == 0) begin
                pin_clk = !pin_clk;
                pin_dt  = 1'($urandom_range(0, 1));
            end
            send_sample();
        end
        pin_btn = 1'b1;
        t_ms += $urandom_range(0, 50);
        send_sample();
    endtask

    task automatic idle_wait();
        int n;
        int i;
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 2))
                0: t_ms += near(sb.dbl_win_ms);
                1: t_ms += near(sb.rapid_gap_ms);
                default: t_ms += $urandom_range(0, 100);
            endcase
            send_sample();
        end
    endtask

    task automatic noise();
        int r;
        pin_clk   = 1'($urandom_range(0, 1));
        pin_dt    = 1'($urandom_range(0, 1));
        pin_btn   = 1'($urandom_range(0, 1));
        menu_open = 1'($urandom_range(0, 1));
        top_menu  = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 9);
        if (r == 0)
            t_ms = $urandom();
        else if (r == 1)
            t_ms = 32'hFFFF_FFFF - $urandom_range(0, 50);
        else
            t_ms += $urandom_range(0, 300);
        send_sample();
    endtask

    task automatic random_gesture();
        int r;
        tx_burst = $urandom_range(0, 3) == 0;
        rx_steady <= $urandom_range(0, 3) == 0;
        if ($urandom_range(0, 3) == 0) begin
            menu_open = 1'($urandom_range(0, 1));
            top_menu  = 1'($urandom_range(0, 1));
        end
        r = $urandom_range(0, 99);
        if (r < 28)
            turn_run();
        else if (r < 52)
            click_run();
        else if (r < 67)
            long_press();
        else if (r < 77)
            idle_wait();
        else if (r < 85) begin
            menu_open = 1'($urandom_range(0, 1));
            top_menu  = 1'($urandom_range(0, 1));
            t_ms += $urandom_range(0, 20);
            send_sample();
        end else
            noise();
    endtask

    // directed opening: encoder paths, long presses, clicks, time extremes
    task automatic directed();
        // idle at time zero
        send_sample();
        // volume up then down
        pin_clk = 1'b0; pin_dt = 1'b1; t_ms = 5;   send_sample();
        pin_clk = 1'b1; pin_dt = 1'b1; t_ms = 10;  send_sample();
        // menu: two forward edges make a step up, two reverse a step down
        menu_open = 1'b1;
        pin_clk = 1'b0; pin_dt = 1'b1; t_ms += 5; send_sample();
        pin_clk = 1'b1; pin_dt = 1'b0; t_ms += 5; send_sample();
        pin_clk = 1'b0; pin_dt = 1'b0; t_ms += 5; send_sample();
        pin_clk = 1'b1; pin_dt = 1'b1; t_ms += 5; send_sample();
        // press on the same sample as an edge clears the seek flag again
        menu_open = 1'b0;
        pin_btn = 1'b0; pin_clk = 1'b0; pin_dt = 1'b1; t_ms += 5; send_sample();
        pin_clk = 1'b1; pin_dt = 1'b0; t_ms += 5; send_sample();
        pin_clk = 1'b0; pin_dt = 1'b0; t_ms += 5; send_sample();
        pin_clk = 1'b1; pin_dt = 1'b1; t_ms += 5; send_sample();
        // long hold after seeking gives no long press
        t_ms += 2500; send_sample();
        pin_btn = 1'b1; t_ms += 5; send_sample();
        // long press in a submenu exits, with a blink on the way
        menu_open = 1'b1; top_menu = 1'b0;
        pin_btn = 1'b0; t_ms += 10;   send_sample();
        t_ms += 2001; send_sample();
        pin_btn = 1'b1; t_ms += 5;    send_sample();
        // long press at the top menu toggles play
        top_menu = 1'b1;
        pin_btn = 1'b0; t_ms += 10;   send_sample();
        t_ms += 2001; send_sample();
        pin_btn = 1'b1; t_ms += 5;    send_sample();
        // double click, then a single click left to expire in a submenu
        top_menu = 1'b0;
        pin_btn = 1'b0; t_ms += 400; send_sample();
        pin_btn = 1'b1; t_ms += 50;  send_sample();
        pin_btn = 1'b0; t_ms += 50;  send_sample();
        pin_btn = 1'b1; t_ms += 50;  send_sample();
        pin_btn = 1'b0; t_ms += 400; send_sample();
        pin_btn = 1'b1; t_ms += 50;  send_sample();
        t_ms += 301; send_sample();
        // all ones, then time wraps to zero
        pin_clk = 1'b1; pin_dt = 1'b1; pin_btn = 1'b1;
        menu_open = 1'b1; top_menu = 1'b1;
        t_ms = 32'hFFFF_FFFF; send_sample();
        t_ms = 32'h0000_0000; send_sample();
    endtask

    task automatic apply_phase(int p);
        case (p)
            1: write_all(20, 60, 30, 3, 3, 10);
            2: write_all(1, 1, 1, 1, 1, 1);
            3: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 15, 7, 16'hFFFF);
            4: write_all(0, 0, 0, 0, 0, 0);
            5: write_all(CFG_W'($urandom_range(1, 1000)), CFG_W'($urandom_range(1, 4000)),
                         CFG_W'($urandom_range(1, 1000)), CFG_W'($urandom_range(1, 15)),
                         CFG_W'($urandom_range(1, 7)), CFG_W'($urandom_range(1, 1000)));
            default:
            begin
                // upper bits beyond a narrow register are dropped
                cfg_write(CFG_UNUSED_IDX, 16'h1234);
                write_all(300, 2000, 500, 16'hFFF3, 16'hFFFD, 500);
            end
        endcase
    endtask

    initial
    begin
        int p;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (p = 0; p < 7; p++) begin
            if (p == 0) begin
                directed();
            end else begin
                drain();
                apply_phase(p);
            end
            phase_samples = 0;
            while (phase_samples < 100)
                random_gesture();
        end
        drain();
        if (sb.errors == 0)
            $display("[encoder_button_gesture_decoder] OK");
        else
            $display("[encoder_button_gesture_decoder] ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("[encoder_button_gesture_decoder] ERROR");
        $finish;
    end

endmodule
